// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the triangle chirp tone generator.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/ttg_pkg.sv =====
// Package of the triangle chirp tone generator: codes, constants and types.
// No dependencies.
`timescale 1ns / 1ps

package ttg_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic KIND_SINGLE = 1'b0;
    localparam logic KIND_RISE   = 1'b1;

    localparam logic [1:0] CFG_STEP_SINGLE      = 2'd0;
    localparam logic [1:0] CFG_STEP_RISE_FIRST  = 2'd1;
    localparam logic [1:0] CFG_STEP_RISE_SECOND = 2'd2;

    localparam logic [15:0] STEP_SINGLE_RESET      = 16'd3031;
    localparam logic [15:0] STEP_RISE_FIRST_RESET  = 16'd2703;
    localparam logic [15:0] STEP_RISE_SECOND_RESET = 16'd3604;

    localparam logic [16:0] QUARTER_TURN  = 17'd16384;
    localparam logic [16:0] THREE_QUARTER = 17'd49152;

    localparam logic [11:0] ATTACK_LEN       = 12'd80;
    localparam logic [11:0] RELEASE_LEN      = 12'd160;
    localparam logic [11:0] SOUND_LEN_SINGLE = 12'd480;
    localparam logic [11:0] SOUND_LEN_RISE   = 12'd1920;
    localparam logic [11:0] LAST_IDX_SINGLE  = 12'd1119;
    localparam logic [11:0] LAST_IDX_RISE    = 12'd2559;
    localparam logic [11:0] RISE_SWITCH      = 12'd960;
    localparam logic [6:0]  ENV_HOLD         = 7'd80;

    // x / 320 = ((x >> 6) * 52429) >> 18, exact for x >> 6 below 2^18
    localparam logic [15:0] DIV5_RECIP = 16'd52429;

    typedef struct packed {
        logic        neg;
        logic [20:0] mag;
        logic [7:0]  vol;
        logic        last;
    } prod_t;

endpackage

// ===== rtl/triangle_chirp_tone_generator.sv =====
// Top level of the triangle chirp tone generator: a DDS triangle with envelope.
// Depends on ttg_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// Takes one item per clock cycle while in_stall is low; a tick during a chirp
// yields its sample on the outputs through the input register, product register
// and result register. The phase, envelope and product are formed before the
// product register, the division by 320 before the result register. Starts and
// ticks while idle yield no result. Stages advance independently, so a waiting
// result stalls the input only when every stage is full.
module triangle_chirp_tone_generator
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic               tone_kind,
    input  logic [7:0]         volume,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] sample,
    output logic [7:0]         sample_volume,
    output logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

`include "assert_macros.svh"

    logic [15:0] step_single_reg;
    logic [15:0] step_rise_first_reg;
    logic [15:0] step_rise_second_reg;

    logic        item_valid_reg;
    logic        item_valid_next;
    logic        item_opcode_reg;
    logic        item_kind_reg;
    logic [7:0]  item_volume_reg;

    logic [15:0] phase_acc_reg;
    logic [15:0] phase_acc_next;
    logic [11:0] sample_index_reg;
    logic [11:0] sample_index_next;
    logic        active_kind_reg;
    logic        active_kind_next;
    logic        playing_reg;
    logic        playing_next;
    logic [7:0]  held_volume_reg;
    logic [7:0]  held_volume_next;

    logic                prod_valid_reg;
    logic                prod_valid_next;
    ttg_pkg::prod_t      prod_reg;
    ttg_pkg::prod_t      prod_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic signed [13:0]  sample_reg;
    logic signed [13:0]  sample_next;
    logic [7:0]          sample_volume_reg;
    logic                last_reg;

    logic        ready_out;
    logic        ready_prod;
    logic        ready_item;
    logic        fire_item;
    logic        is_tick;

    logic [11:0] t;
    logic [15:0] step;
    logic [11:0] sound_len;
    logic [11:0] last_idx;
    logic [15:0] phase_sum;
    logic [16:0] tri_val;
    logic [16:0] tri_abs;
    logic [11:0] remain;
    logic [6:0]  env;
    logic        at_last;

    logic [14:0] div_in;
    logic [30:0] div_prod;
    logic [12:0] quot;

    assign ready_out  = !out_valid_reg || !out_stall;
    assign ready_prod = !prod_valid_reg || ready_out;
    assign ready_item = !item_valid_reg || ready_prod;
    assign in_stall   = !ready_item;
    assign fire_item  = item_valid_reg && ready_prod;
    assign is_tick    = item_opcode_reg == ttg_pkg::OP_TICK;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_single_reg      <= ttg_pkg::STEP_SINGLE_RESET;
            step_rise_first_reg  <= ttg_pkg::STEP_RISE_FIRST_RESET;
            step_rise_second_reg <= ttg_pkg::STEP_RISE_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ttg_pkg::CFG_STEP_SINGLE:      step_single_reg      <= cfg_data;
                ttg_pkg::CFG_STEP_RISE_FIRST:  step_rise_first_reg  <= cfg_data;
                ttg_pkg::CFG_STEP_RISE_SECOND: step_rise_second_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // phase, envelope and product of the held item
    always_comb
    begin
        t = sample_index_reg;
        if (active_kind_reg == ttg_pkg::KIND_RISE)
        begin
            step      = (t < ttg_pkg::RISE_SWITCH) ? step_rise_first_reg : step_rise_second_reg;
            sound_len = ttg_pkg::SOUND_LEN_RISE;
            last_idx  = ttg_pkg::LAST_IDX_RISE;
        end
        else
        begin
            step      = step_single_reg;
            sound_len = ttg_pkg::SOUND_LEN_SINGLE;
            last_idx  = ttg_pkg::LAST_IDX_SINGLE;
        end
        phase_sum = phase_acc_reg + step;

        if (!phase_sum[15])
            tri_val = {1'b0, phase_sum} - ttg_pkg::QUARTER_TURN;
        else
            tri_val = ttg_pkg::THREE_QUARTER - {1'b0, phase_sum};
        tri_abs = tri_val[16] ? (~tri_val + 17'd1) : tri_val;

        remain = sound_len - t;
        if (t < ttg_pkg::ATTACK_LEN)
            env = t[6:0];
        else if (t >= sound_len)
            env = 7'd0;
        else if (remain < ttg_pkg::RELEASE_LEN)
            env = remain[7:1];
        else
            env = ttg_pkg::ENV_HOLD;

        at_last = t >= last_idx;

        prod_next.neg  = tri_val[16];
        prod_next.mag  = 21'(tri_abs[14:0] * env);
        prod_next.vol  = held_volume_reg;
        prod_next.last = at_last;
    end

    // chirp state
    always_comb
    begin
        phase_acc_next    = phase_acc_reg;
        sample_index_next = sample_index_reg;
        active_kind_next  = active_kind_reg;
        playing_next      = playing_reg;
        held_volume_next  = held_volume_reg;
        if (fire_item)
        begin
            if (!is_tick)
            begin
                if (item_volume_reg != 8'd0)
                begin
                    phase_acc_next    = '0;
                    sample_index_next = '0;
                    active_kind_next  = item_kind_reg;
                    held_volume_next  = item_volume_reg;
                    playing_next      = 1'b1;
                end
            end
            else if (playing_reg)
            begin
                phase_acc_next = phase_sum;
                if (at_last)
                begin
                    sample_index_next = '0;
                    playing_next      = 1'b0;
                end
                else
                begin
                    sample_index_next = t + 12'd1;
                end
            end
        end
    end

    // divide by 320 and restore the sign
    always_comb
    begin
        div_in      = prod_reg.mag[20:6];
        div_prod    = div_in * ttg_pkg::DIV5_RECIP;
        quot        = div_prod[30:18];
        sample_next = prod_reg.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_comb
    begin
        item_valid_next = ready_item ? in_valid : item_valid_reg;
        prod_valid_next = ready_prod ? (fire_item && is_tick && playing_reg) : prod_valid_reg;
        out_valid_next  = ready_out ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            prod_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            active_kind_reg  <= ttg_pkg::KIND_SINGLE;
            playing_reg      <= 1'b0;
            held_volume_reg  <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            prod_valid_reg   <= prod_valid_next;
            out_valid_reg    <= out_valid_next;
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
            active_kind_reg  <= active_kind_next;
            playing_reg      <= playing_next;
            held_volume_reg  <= held_volume_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready_item)
        begin
            item_opcode_reg <= opcode;
            item_kind_reg   <= tone_kind;
            item_volume_reg <= volume;
        end
        if (ready_prod)
            prod_reg <= prod_next;
        if (ready_out)
        begin
            sample_reg        <= sample_next;
            sample_volume_reg <= prod_reg.vol;
            last_reg          <= prod_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign sample_volume = sample_volume_reg;
    assign last          = last_reg;

    `ASSERT_IMPLIES(a_idle_index_clear, clk, rst_n, !playing_reg,
        sample_index_reg == 12'd0, "index not cleared while idle")
    `ASSERT_IMPLIES(a_single_index_range, clk, rst_n, active_kind_reg == ttg_pkg::KIND_SINGLE,
        sample_index_reg <= ttg_pkg::LAST_IDX_SINGLE, "single tone index out of range")
    `ASSERT_IMPLIES(a_sample_range, clk, rst_n, out_valid_reg,
        (sample_reg <= 14'sd4096) && (sample_reg >= -14'sd4096), "sample out of range")
    `ASSERT_HOLDS(a_result_from_tick, clk, rst_n,
        $rose(prod_valid_reg) |-> $past(fire_item && is_tick && playing_reg),
        "result without a tick while playing")

endmodule

// ===== tb/sv/triangle_chirp_tone_generator_test.sv =====
// Self-checking testbench of the triangle chirp tone generator: a directed table,
// then random chirps under four idle patterns and several step settings.
// Depends on ttg_pkg and the triangle_chirp_tone_generator RTL.
`timescale 1ns / 1ps

module triangle_chirp_tone_generator_test;

    localparam int HALF_TURN     = 32768;
    localparam int ENV_DIV       = 320;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CAP     = 20000;
    localparam int PHASE_QUOTA   = 233;

    typedef struct packed {
        logic signed [13:0] smp;
        logic [7:0]         vol;
        logic               last;
    } chirp_sample_t;

    typedef struct packed {
        logic          op;
        logic          kind;
        logic [7:0]    vol;
        logic          typed;
        logic          yields;
        chirp_sample_t res;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               opcode;
    logic               tone_kind;
    logic [7:0]         volume;
    logic               out_valid;
    logic               out_stall;
    logic signed [13:0] sample;
    logic [7:0]         sample_volume;
    logic               last;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    // predicted state of the generator
    logic [15:0] tone_step;
    logic [15:0] rise_step_lo;
    logic [15:0] rise_step_hi;
    logic [15:0] phase_acc;
    logic [11:0] sample_idx;
    logic        chirp_kind;
    logic        chirp_on;
    logic [7:0]  chirp_vol;

    chirp_sample_t pending_samples[$];
    chirp_sample_t oldest;
    directed_row_t directed_rows[18];
    int            error_count;
    int unsigned   send_idle_pct;
    int unsigned   stall_pct;

    triangle_chirp_tone_generator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .tone_kind     (tone_kind),
        .volume        (volume),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .sample_volume (sample_volume),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("sample %0d with no expectation waiting", sample);
                error_count++;
            end
            else
            begin
                oldest = pending_samples.pop_front();
                if (sample !== oldest.smp)
                begin
                    $error("sample: expected %0d, got %0d", oldest.smp, sample);
                    error_count++;
                end
                if (sample_volume !== oldest.vol)
                begin
                    $error("sample_volume: expected %0d, got %0d", oldest.vol, sample_volume);
                    error_count++;
                end
                if (last !== oldest.last)
                begin
                    $error("last: expected %0d, got %0d", oldest.last, last);
                    error_count++;
                end
            end
        end
    end

    function automatic bit chirp_predict(input logic op, input logic kind,
                                         input logic [7:0] vol, output chirp_sample_t res);
        int          t;
        int          len;
        int          last_idx;
        int          p;
        int          tri_v;
        int          env;
        int          s;
        logic [15:0] step;
        res = '0;
        if (op == ttg_pkg::OP_START)
        begin
            if (vol != 8'd0)
            begin
                phase_acc  = '0;
                sample_idx = '0;
                chirp_kind = kind;
                chirp_vol  = vol;
                chirp_on   = 1'b1;
            end
            return 1'b0;
        end
        if (!chirp_on)
            return 1'b0;
        t = int'(sample_idx);
        if (chirp_kind == ttg_pkg::KIND_RISE)
        begin
            step     = (t < int'(ttg_pkg::RISE_SWITCH)) ? rise_step_lo : rise_step_hi;
            len      = int'(ttg_pkg::SOUND_LEN_RISE);
            last_idx = int'(ttg_pkg::LAST_IDX_RISE);
        end
        else
        begin
            step     = tone_step;
            len      = int'(ttg_pkg::SOUND_LEN_SINGLE);
            last_idx = int'(ttg_pkg::LAST_IDX_SINGLE);
        end
        phase_acc = phase_acc + step;
        p = int'({16'd0, phase_acc});
        tri_v = (p < HALF_TURN) ? p - int'(ttg_pkg::QUARTER_TURN)
                                : int'(ttg_pkg::THREE_QUARTER) - p;
        if (t < int'(ttg_pkg::ATTACK_LEN))
            env = t;
        else if (t >= len)
            env = 0;
        else if (len - t < int'(ttg_pkg::RELEASE_LEN))
            env = (len - t) / 2;
        else
            env = int'(ttg_pkg::ENV_HOLD);
        s = tri_v * env / ENV_DIV;
        res.smp = s[13:0];
        res.vol = chirp_vol;
        if (t >= last_idx)
        begin
            res.last   = 1'b1;
            chirp_on   = 1'b0;
            sample_idx = '0;
        end
        else
        begin
            res.last   = 1'b0;
            sample_idx = sample_idx + 12'd1;
        end
        return 1'b1;
    endfunction

    task automatic offer_item(input logic op, input logic kind, input logic [7:0] vol);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        tone_kind <= kind;
        volume    <= vol;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
    endtask

    task automatic issue(input logic op, input logic kind, input logic [7:0] vol,
                         inout int counted);
        chirp_sample_t res;
        bit            yields;
        offer_item(op, kind, vol);
        yields = chirp_predict(op, kind, vol, res);
        if (yields)
            pending_samples.push_back(res);
        counted++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_CAP && pending_samples.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_steps(input logic [15:0] single, input logic [15:0] rise_lo,
                               input logic [15:0] rise_hi);
        cfg_we    <= 1'b1;
        cfg_index <= ttg_pkg::CFG_STEP_SINGLE;
        cfg_data  <= single;
        @(posedge clk);
        tone_step = single;
        cfg_index <= ttg_pkg::CFG_STEP_RISE_FIRST;
        cfg_data  <= rise_lo;
        @(posedge clk);
        rise_step_lo = rise_lo;
        cfg_index <= ttg_pkg::CFG_STEP_RISE_SECOND;
        cfg_data  <= rise_hi;
        @(posedge clk);
        rise_step_hi = rise_hi;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_chirps(input int quota);
        int         counted;
        int         len;
        logic [7:0] vol;
        counted = 0;
        while (counted < quota)
        begin
            if ($urandom_range(99) < 85)
            begin
                case ($urandom_range(9))
                    0:       vol = 8'd1;
                    1:       vol = 8'd255;
                    default: vol = 8'($urandom_range(255, 1));
                endcase
                issue(ttg_pkg::OP_START, 1'($urandom_range(1)), vol, counted);
                len = ($urandom_range(9) == 0) ? $urandom_range(600, 1) : $urandom_range(120, 1);
                if (len > quota - counted)
                    len = quota - counted;
                repeat (len)
                begin
                    if ($urandom_range(99) < 4)
                        issue(ttg_pkg::OP_START, 1'($urandom_range(1)), 8'd0, counted);
                    issue(ttg_pkg::OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                          counted);
                end
            end
            else
                issue(1'($urandom_range(1)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), counted);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        chirp_sample_t res;
        bit            yields;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = ttg_pkg::OP_START;
        tone_kind     = ttg_pkg::KIND_SINGLE;
        volume        = 8'd0;
        cfg_we        = 1'b0;
        cfg_index     = ttg_pkg::CFG_STEP_SINGLE;
        cfg_data      = 16'd0;
        send_idle_pct = 0;
        stall_pct     = 0;
        error_count   = 0;

        tone_step    = ttg_pkg::STEP_SINGLE_RESET;
        rise_step_lo = ttg_pkg::STEP_RISE_FIRST_RESET;
        rise_step_hi = ttg_pkg::STEP_RISE_SECOND_RESET;
        phase_acc    = '0;
        sample_idx   = '0;
        chirp_kind   = ttg_pkg::KIND_SINGLE;
        chirp_on     = 1'b0;
        chirp_vol    = '0;

        directed_rows = '{
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_RISE, 8'd255, 1'b1, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_START, ttg_pkg::KIND_RISE, 8'd0, 1'b1, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_SINGLE, 8'd0, 1'b1, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_START, ttg_pkg::KIND_SINGLE, 8'd255, 1'b1, 1'b0,
              '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_SINGLE, 8'd0, 1'b1, 1'b1,
              '{14'sd0, 8'd255, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_RISE, 8'd1, 1'b0, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_RISE, 8'd7, 1'b0, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_START, ttg_pkg::KIND_RISE, 8'd0, 1'b1, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_SINGLE, 8'd255, 1'b0, 1'b0,
              '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_START, ttg_pkg::KIND_RISE, 8'd1, 1'b1, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_SINGLE, 8'd0, 1'b1, 1'b1, '{14'sd0, 8'd1, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_SINGLE, 8'd0, 1'b0, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_RISE, 8'd128, 1'b0, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_START, ttg_pkg::KIND_SINGLE, 8'd128, 1'b1, 1'b0,
              '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_SINGLE, 8'd0, 1'b1, 1'b1,
              '{14'sd0, 8'd128, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_RISE, 8'd255, 1'b0, 1'b0, '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_START, ttg_pkg::KIND_SINGLE, 8'd0, 1'b1, 1'b0,
              '{14'sd0, 8'd0, 1'b0}},
            '{ttg_pkg::OP_TICK, ttg_pkg::KIND_SINGLE, 8'd0, 1'b0, 1'b0, '{14'sd0, 8'd0, 1'b0}}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].op, directed_rows[i].kind, directed_rows[i].vol);
            yields = chirp_predict(directed_rows[i].op, directed_rows[i].kind,
                                   directed_rows[i].vol, res);
            if (directed_rows[i].typed)
            begin
                if (directed_rows[i].yields)
                    pending_samples.push_back(directed_rows[i].res);
            end
            else if (yields)
                pending_samples.push_back(res);
        end
        // hold the sender until every sample is back
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    write_steps(16'd32768, 16'd0, 16'd65535);
                end
                1:
                begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                    write_steps(16'd65535, 16'd32768, 16'd0);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                    write_steps(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                16'($urandom_range(65535)));
                end
                default:
                begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                    write_steps(16'd0, 16'd65535, 16'd32768);
                end
            endcase
            random_chirps(PHASE_QUOTA);
            drain();
        end

        if (pending_samples.size() != 0)
        begin
            $error("%0d expected samples never arrived", pending_samples.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
